@@ rtl/p2cfl_pkg.sv @@
// Shared types, codes and default sizes for the power-of-two chunk free lists.
`default_nettype none
package p2cfl_pkg;

    // defaults for the top-level parameters
    localparam int NUM_CHUNKS_DEF  = 1024;
    localparam int NUM_CLASSES_DEF = 16;
    localparam int CHUNK_LOG_DEF   = 21;

    // fixed field widths
    localparam int OP_W     = 2;
    localparam int SIZE_W   = 40;
    localparam int CHUNK_W  = 10;
    localparam int STATUS_W = 2;
    localparam int CLASS_W  = 4;

    typedef enum logic [OP_W-1:0] {
        OP_ALLOC  = 2'd0,
        OP_RECORD = 2'd1,
        OP_FREE   = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK         = 2'd0,
        ST_EMPTY      = 2'd1,
        ST_TOO_LARGE  = 2'd2,
        ST_CHUNK_ZERO = 2'd3
    } status_t;

endpackage
`default_nettype wire

@@ rtl/power_of_two_chunk_free_lists_unit.sv @@
// Top level: segregated power-of-two free lists of chunks with LIFO pop and push.
//
// Each item passes through the states S_EXEC and S_WB. The accept edge works out the
// size class (round up to chunks, then to a power of two); S_EXEC reads
// the list head and issues the link and class RAM reads; S_WB takes the
// registered RAM data, writes the heads, links and classes back and loads the
// result register. The next item is accepted during S_WB once the output slot
// is free or being taken, so a stalled result holds off the next item. A result
// waits in the output register while a new item comes in.
// The link and class stores are plain RAMs with no reset and no clearing pass;
// only the list heads are cleared by reset.
`default_nettype none
module power_of_two_chunk_free_lists_unit
    import p2cfl_pkg::*;
#(
    parameter int NUM_CHUNKS  = NUM_CHUNKS_DEF,
    parameter int NUM_CLASSES = NUM_CLASSES_DEF,
    parameter int CHUNK_LOG   = CHUNK_LOG_DEF
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire logic [OP_W-1:0]     s_operation,
    input  wire logic [SIZE_W-1:0]   s_size_bytes,
    input  wire logic [CHUNK_W-1:0]  s_chunk_number,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output logic [STATUS_W-1:0]      m_status,
    output logic [CHUNK_W-1:0]       m_granted_chunk,
    output logic [CLASS_W-1:0]       m_size_class
);

    // chunk-count width after rounding, and width of a computed class
    localparam int NW    = SIZE_W + 1 - CHUNK_LOG;
    localparam int KBITS = $clog2(NW + 1);
    // RAM address width and stored class width
    localparam int CW    = (NUM_CHUNKS > 1) ? $clog2(NUM_CHUNKS) : 1;
    localparam int CLW   = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
    localparam logic [SIZE_W:0] ROUND = (SIZE_W + 1)'((64'd1 << CHUNK_LOG) - 64'd1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_WB
    } state_t;

    // ceil(log2(ceil(size / chunk))), size zero counting as one chunk
    function automatic logic [KBITS-1:0] class_of_size(input logic [SIZE_W-1:0] size);
        logic [SIZE_W:0]    sum;
        logic [NW-1:0]      n;
        logic [NW-1:0]      v;
        logic [KBITS-1:0]   k;
        sum = {1'b0, size} + ROUND;
        n   = sum[SIZE_W:CHUNK_LOG];
        v   = n - NW'(1);
        k   = '0;
        if (n > NW'(1)) begin
            for (int i = 0; i < NW; i++) begin
                if (v[i]) begin
                    k = KBITS'(i + 1);
                end
            end
        end
        return k;
    endfunction

    // control and item registers
    state_t                 state_reg, state_next;
    op_t                    op_reg, op_next;
    logic [CHUNK_W-1:0]     chunk_reg, chunk_next;
    logic [KBITS-1:0]       k_reg, k_next;
    logic                   too_large_reg, too_large_next;
    logic [CHUNK_W-1:0]     head_reg, head_next;

    // result register
    logic                   m_valid_reg, m_valid_next;
    status_t                status_reg, status_next;
    logic [CHUNK_W-1:0]     granted_reg, granted_next;
    logic [CLASS_W-1:0]     cls_reg, cls_next;

    // list heads, cleared by reset (zero means empty)
    logic [CHUNK_W-1:0]     heads_reg [NUM_CLASSES];
    logic                   heads_we;
    logic [CLW-1:0]         heads_widx;
    logic [CHUNK_W-1:0]     heads_wdata;
    logic [CLW-1:0]         head_idx;
    logic [CHUNK_W-1:0]     head_rd;

    // RAM ports
    logic                   link_we, link_re;
    logic [CW-1:0]          link_waddr, link_raddr;
    logic [CHUNK_W-1:0]     link_wdata, link_rd;
    logic                   cls_we, cls_re;
    logic [CW-1:0]          cls_waddr, cls_raddr;
    logic [CLW-1:0]         cls_wdata, cls_rd;

    // helpers
    logic                   accept;
    logic                   wb_go;
    logic [KBITS-1:0]       k_in;
    logic [CLW-1:0]         k_idx;
    logic [CLW-1:0]         kf_idx;
    logic                   kf_big;
    logic                   chunk_ok;
    logic                   head_empty;

    // next-pointer store and recorded-class store
    p2cfl_ram #(
        .WIDTH (CHUNK_W),
        .DEPTH (NUM_CHUNKS)
    ) u_links (
        .aclk    (aclk),
        .wr_en   (link_we),
        .wr_addr (link_waddr),
        .wr_data (link_wdata),
        .rd_en   (link_re),
        .rd_addr (link_raddr),
        .rd_data (link_rd)
    );

    p2cfl_ram #(
        .WIDTH (CLW),
        .DEPTH (NUM_CHUNKS)
    ) u_classes (
        .aclk    (aclk),
        .wr_en   (cls_we),
        .wr_addr (cls_waddr),
        .wr_data (cls_wdata),
        .rd_en   (cls_re),
        .rd_addr (cls_raddr),
        .rd_data (cls_rd)
    );

    // output slot frees up this cycle or is already empty
    assign wb_go   = !m_valid_reg || m_ready;
    assign s_ready = (state_reg == S_IDLE) || ((state_reg == S_WB) && wb_go);
    assign accept  = s_valid && s_ready;
    assign k_in    = class_of_size(s_size_bytes);

    // out-of-range class indexes are steered to zero; their results are masked
    assign k_idx   = too_large_reg ? '0 : CLW'(k_reg);
    assign kf_big  = 32'(cls_rd) >= NUM_CLASSES;
    assign kf_idx  = kf_big ? '0 : cls_rd;

    // one heads read port: the allocate class while reading, the freed chunk's class
    // during write-back
    assign head_idx   = (state_reg == S_WB) ? kf_idx : k_idx;
    assign head_rd    = heads_reg[head_idx];

    assign chunk_ok   = (chunk_reg != '0) && (32'(chunk_reg) < NUM_CHUNKS);
    assign head_empty = (head_reg == '0) || (32'(head_reg) >= NUM_CHUNKS);

    // reads are issued from the item registers in the first cycle
    assign link_re    = (state_reg == S_EXEC);
    assign link_raddr = CW'(head_rd);
    assign cls_re     = (state_reg == S_EXEC);
    assign cls_raddr  = CW'(chunk_reg);

    always_comb begin
        state_next     = state_reg;
        op_next        = op_reg;
        chunk_next     = chunk_reg;
        k_next         = k_reg;
        too_large_next = too_large_reg;
        head_next      = head_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        status_next    = status_reg;
        granted_next   = granted_reg;
        cls_next       = cls_reg;

        heads_we    = 1'b0;
        heads_widx  = k_idx;
        heads_wdata = '0;
        link_we     = 1'b0;
        link_waddr  = CW'(chunk_reg);
        link_wdata  = head_rd;
        cls_we      = 1'b0;
        cls_waddr   = CW'(chunk_reg);
        cls_wdata   = CLW'(k_reg);

        if (accept) begin
            op_next        = op_t'(s_operation);
            chunk_next     = s_chunk_number;
            k_next         = k_in;
            too_large_next = 32'(k_in) >= NUM_CLASSES;
        end

        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                head_next  = too_large_reg ? '0 : head_rd;
                state_next = S_WB;
            end
            S_WB: begin
                if (wb_go) begin
                    m_valid_next = 1'b1;
                    status_next  = ST_OK;
                    granted_next = '0;
                    cls_next     = '0;
                    case (op_reg)
                        OP_ALLOC: begin
                            if (too_large_reg) begin
                                status_next = ST_TOO_LARGE;
                            end else if (head_empty) begin
                                status_next = ST_EMPTY;
                                cls_next    = CLASS_W'(k_reg);
                            end else begin
                                // pop: head takes the link, the chunk takes this class
                                heads_we     = 1'b1;
                                heads_widx   = k_idx;
                                heads_wdata  = link_rd;
                                cls_we       = 1'b1;
                                cls_waddr    = CW'(head_reg);
                                granted_next = head_reg;
                                cls_next     = CLASS_W'(k_reg);
                            end
                        end
                        OP_RECORD: begin
                            if (!chunk_ok) begin
                                status_next = ST_CHUNK_ZERO;
                            end else if (too_large_reg) begin
                                status_next = ST_TOO_LARGE;
                            end else begin
                                cls_we   = 1'b1;
                                cls_next = CLASS_W'(k_reg);
                            end
                        end
                        OP_FREE: begin
                            if (!chunk_ok) begin
                                status_next = ST_CHUNK_ZERO;
                            end else if (kf_big) begin
                                status_next = ST_TOO_LARGE;
                            end else begin
                                // push: link to old head, chunk becomes head
                                link_we     = 1'b1;
                                heads_we    = 1'b1;
                                heads_widx  = kf_idx;
                                heads_wdata = chunk_reg;
                                cls_next    = CLASS_W'(cls_rd);
                            end
                        end
                        default: begin
                            // unused code: no state change, all-zero ok result
                        end
                    endcase
                    state_next = accept ? S_EXEC : S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
        op_reg        <= op_next;
        chunk_reg     <= chunk_next;
        k_reg         <= k_next;
        too_large_reg <= too_large_next;
        head_reg      <= head_next;
        status_reg    <= status_next;
        granted_reg   <= granted_next;
        cls_reg       <= cls_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_CLASSES; i++) begin
                heads_reg[i] <= '0;
            end
        end else if (heads_we) begin
            heads_reg[heads_widx] <= heads_wdata;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_status        = status_reg;
    assign m_granted_chunk = granted_reg;
    assign m_size_class    = cls_reg;

endmodule
`default_nettype wire

@@ rtl/p2cfl_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module p2cfl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

@@ rtl/p2cfl_checker.sv @@
// Port-level assertions for the free-list unit, bound to the top level.
`default_nettype none
module p2cfl_checker
    import p2cfl_pkg::*;
(
    input wire logic                aclk,
    input wire logic                aresetn,
    input wire logic                s_valid,
    input wire logic                s_ready,
    input wire logic                m_valid,
    input wire logic                m_ready,
    input wire logic [STATUS_W-1:0] m_status,
    input wire logic [CHUNK_W-1:0]  m_granted_chunk,
    input wire logic [CLASS_W-1:0]  m_size_class
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        aresetn && m_valid && !m_ready |=> m_valid && $stable(m_status)
            && $stable(m_granted_chunk) && $stable(m_size_class))
        else $error("stalled result changed");

    // an accepted item occupies the unit for the following cycle
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        aresetn && s_valid && s_ready |=> !s_ready)
        else $error("input accepted on consecutive cycles");

    // a granted chunk only comes with an ok status
    a_grant_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_granted_chunk != '0) |-> (m_status == ST_OK))
        else $error("chunk granted with error status");

    // rejected items report neither chunk nor class
    a_reject_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && ((m_status == ST_TOO_LARGE) || (m_status == ST_CHUNK_ZERO))
            |-> (m_granted_chunk == '0) && (m_size_class == '0))
        else $error("rejected item carries chunk or class");

endmodule

bind power_of_two_chunk_free_lists_unit p2cfl_checker u_p2cfl_checker (.*);
`default_nettype wire

@@ test/testbench.sv @@
// Self-checking testbench for the power-of-two chunk free lists unit.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import p2cfl_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int REPORT_MAX  = 10;
    localparam logic [SIZE_W-1:0] SIZE_MAX    = '1;
    localparam logic [SIZE_W-1:0] CHUNK_BYTES = SIZE_W'(1) << CHUNK_LOG_DEF;

    // one result item as the block returns it
    typedef struct packed {
        status_t            status;
        logic [CHUNK_W-1:0] granted;
        logic [CLASS_W-1:0] cls;
    } list_result_t;

    // DUT connections, every input known from time zero
    logic               aclk           = 1'b0;
    logic               aresetn        = 1'b0;
    logic               s_valid        = 1'b0;
    logic               s_ready;
    logic [OP_W-1:0]    s_operation    = OP_NONE;
    logic [SIZE_W-1:0]  s_size_bytes   = '0;
    logic [CHUNK_W-1:0] s_chunk_number = '0;
    logic               m_valid;
    logic               m_ready        = 1'b0;
    logic [STATUS_W-1:0] m_status;
    logic [CHUNK_W-1:0] m_granted_chunk;
    logic [CLASS_W-1:0] m_size_class;

    // shadow copy of the free lists
    logic [CHUNK_W-1:0] head_of_class  [NUM_CLASSES_DEF] = '{default: '0};
    logic [CHUNK_W-1:0] next_chunk     [NUM_CHUNKS_DEF];
    logic [CLASS_W-1:0] class_of_chunk [NUM_CHUNKS_DEF];
    bit                 class_written  [NUM_CHUNKS_DEF];

    list_result_t       expected_results[$];
    list_result_t       last_result;

    // chunks the host side currently holds; only these are freed in well-formed traffic
    logic [CHUNK_W-1:0] owned_chunks[$];
    bit                 is_owned [NUM_CHUNKS_DEF];
    int                 fresh_next = 16;

    int gap_level   = 0;
    int stall_level = 0;
    int stall_left  = 0;
    int cycle_count = 0;
    int error_count = 0;
    int items_sent  = 0;
    int results_checked = 0;
    int alloc_hits  = 0;
    int alloc_misses = 0;
    int frees_pushed = 0;

    power_of_two_chunk_free_lists_unit i_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_operation     (s_operation),
        .s_size_bytes    (s_size_bytes),
        .s_chunk_number  (s_chunk_number),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_status        (m_status),
        .m_granted_chunk (m_granted_chunk),
        .m_size_class    (m_size_class)
    );

    always #4 aclk = ~aclk;

    // hard stop in case the block hangs
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results still due", cycle_count,
                     expected_results.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // result side back-pressure: m_ready is held low in random bursts
    always @(posedge aclk) begin
        if (stall_left > 0) begin
            m_ready    <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (stall_level > 0 && $urandom_range(99) < stall_level) begin
            m_ready    <= 1'b0;
            stall_left <= $urandom_range(13);
        end else begin
            m_ready <= 1'b1;
        end
    end

    task automatic log_error(input string what);
        error_count++;
        if (error_count <= REPORT_MAX)
            $display("%s", what);
    endtask

    // every accepted result is checked against the oldest outstanding prediction
    always @(posedge aclk) begin : check_results
        list_result_t want;
        if (aresetn && m_valid && m_ready) begin
            results_checked++;
            if (expected_results.size() == 0) begin
                log_error($sformatf("Unexpected result: status %0d chunk %0d class %0d",
                                    m_status, m_granted_chunk, m_size_class));
            end else begin
                want = expected_results.pop_front();
                if (m_status !== want.status || m_granted_chunk !== want.granted ||
                    m_size_class !== want.cls)
                    log_error($sformatf({"Result %0d: expected status %0d chunk %0d ",
                                         "class %0d, got status %0d chunk %0d class %0d"},
                                        results_checked, want.status, want.granted,
                                        want.cls, m_status, m_granted_chunk,
                                        m_size_class));
            end
        end
    end

    // round up to whole chunks, then up to a power of two; the log is the class
    function automatic int class_from_size(input logic [SIZE_W-1:0] size);
        logic [63:0] chunks;
        logic [63:0] rest;
        int          k;
        chunks = (64'(size) + (64'd1 << CHUNK_LOG_DEF) - 64'd1) >> CHUNK_LOG_DEF;
        k = 0;
        if (chunks <= 64'd1)
            return 0;
        rest = chunks - 64'd1;
        while (rest != 64'd0) begin
            k++;
            rest >>= 1;
        end
        return k;
    endfunction

    // apply one item to the shadow lists and return what the block should answer
    function automatic list_result_t apply_item(input op_t op,
                                                 input logic [SIZE_W-1:0] size,
                                                 input logic [CHUNK_W-1:0] chunk);
        list_result_t res;
        int           k;
        logic [CHUNK_W-1:0] top;
        bit           chunk_ok;
        res = '{status: ST_OK, granted: '0, cls: '0};
        chunk_ok = (chunk != '0) && (int'(chunk) < NUM_CHUNKS_DEF);
        case (op)
            OP_ALLOC: begin
                k = class_from_size(size);
                if (k >= NUM_CLASSES_DEF) begin
                    res.status = ST_TOO_LARGE;
                end else begin
                    top     = head_of_class[k];
                    res.cls = CLASS_W'(k);
                    if (top == '0) begin
                        res.status = ST_EMPTY;
                        alloc_misses++;
                    end else begin
                        head_of_class[k]    = next_chunk[top];
                        class_of_chunk[top] = CLASS_W'(k);
                        class_written[top]  = 1'b1;
                        res.granted         = top;
                        alloc_hits++;
                    end
                end
            end
            OP_RECORD: begin
                k = class_from_size(size);
                if (!chunk_ok) begin
                    res.status = ST_CHUNK_ZERO;
                end else if (k >= NUM_CLASSES_DEF) begin
                    res.status = ST_TOO_LARGE;
                end else begin
                    class_of_chunk[chunk] = CLASS_W'(k);
                    class_written[chunk]  = 1'b1;
                    res.cls               = CLASS_W'(k);
                end
            end
            OP_FREE: begin
                if (!chunk_ok) begin
                    res.status = ST_CHUNK_ZERO;
                end else begin
                    k = class_of_chunk[chunk];
                    if (k >= NUM_CLASSES_DEF) begin
                        res.status = ST_TOO_LARGE;
                    end else begin
                        next_chunk[chunk] = head_of_class[k];
                        head_of_class[k]  = chunk;
                        res.cls           = CLASS_W'(k);
                        frees_pushed++;
                    end
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    // offer one item, with an optional idle burst first; valid stays up afterwards
    task automatic send_item(input op_t op, input logic [SIZE_W-1:0] size,
                             input logic [CHUNK_W-1:0] chunk);
        if (gap_level > 0 && $urandom_range(99) < gap_level) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(14, 1)) @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_operation    <= op;
        s_size_bytes   <= size;
        s_chunk_number <= chunk;
        do
            @(posedge aclk);
        while (!s_ready);
        last_result = apply_item(op, size, chunk);
        expected_results.push_back(last_result);
        items_sent++;
    endtask

    task automatic wait_results_drained();
        s_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge aclk);
    endtask

    function automatic logic [SIZE_W-1:0] any_size();
        return SIZE_W'({$urandom, $urandom});
    endfunction

    // a byte size that lands in class k, often right on a class boundary
    function automatic logic [SIZE_W-1:0] size_for_class(input int k);
        logic [63:0] lo;
        logic [63:0] hi;
        logic [63:0] pick;
        if (k == 0) begin
            lo = 64'd0;
            hi = 64'd1 << CHUNK_LOG_DEF;
        end else begin
            lo = (64'd1 << (CHUNK_LOG_DEF + k - 1)) + 64'd1;
            hi = 64'd1 << (CHUNK_LOG_DEF + k);
        end
        if (hi > 64'(SIZE_MAX))
            hi = 64'(SIZE_MAX);
        case ($urandom_range(5))
            0:       pick = lo;
            1:       pick = hi;
            default: pick = lo + ({$urandom, $urandom} % (hi - lo + 64'd1));
        endcase
        return pick[SIZE_W-1:0];
    endfunction

    // small classes dominate so the lists actually fill and empty
    function automatic int random_class();
        int r;
        r = $urandom_range(99);
        if (r < 70)
            return $urandom_range(4);
        if (r < 95)
            return $urandom_range(NUM_CLASSES_DEF - 1);
        return $urandom_range(19, NUM_CLASSES_DEF);
    endfunction

    function automatic logic [CHUNK_W-1:0] fresh_chunk();
        if (fresh_next < NUM_CHUNKS_DEF) begin
            fresh_next++;
            return CHUNK_W'(fresh_next - 1);
        end
        return CHUNK_W'($urandom_range(NUM_CHUNKS_DEF - 1, 1));
    endfunction

    function automatic void claim_chunk(input logic [CHUNK_W-1:0] chunk);
        if (!is_owned[chunk]) begin
            is_owned[chunk] = 1'b1;
            owned_chunks.push_back(chunk);
        end
    endfunction

    // odd items: unused code, invalid chunks, oversize requests, repeat frees
    task automatic send_noise_item();
        logic [CHUNK_W-1:0] chunk;
        chunk = CHUNK_W'($urandom_range(NUM_CHUNKS_DEF - 1, 1));
        case ($urandom_range(4))
            0: send_item(OP_NONE, any_size(), CHUNK_W'($urandom));
            1: send_item(OP_RECORD, any_size(), CHUNK_W'($urandom));
            2: send_item(OP_FREE, any_size(), '0);
            // only chunks with a known class may be freed again
            3: send_item(OP_FREE, any_size(), class_written[chunk] ? chunk : '0);
            default: send_item(OP_ALLOC, any_size(), CHUNK_W'($urandom));
        endcase
    endtask

    // class boundaries, size zero and the oversize edge, all on empty lists
    task automatic test_size_classes();
        send_item(OP_ALLOC, '0, '0);
        send_item(OP_ALLOC, CHUNK_BYTES, '1);
        send_item(OP_ALLOC, CHUNK_BYTES + 1, '0);
        send_item(OP_ALLOC, CHUNK_BYTES << 15, '0);
        send_item(OP_ALLOC, (CHUNK_BYTES << 15) + 1, '0);
        send_item(OP_ALLOC, SIZE_MAX, '1);
    endtask

    // chunk zero is refused before the size is looked at
    task automatic test_chunk_checks();
        send_item(OP_RECORD, SIZE_MAX, '0);
        send_item(OP_FREE, '0, '0);
        send_item(OP_RECORD, SIZE_MAX, CHUNK_W'(5));
    endtask

    // pushes and pops come back last in, first out, and pops retag the class
    task automatic test_lifo_order();
        send_item(OP_RECORD, CHUNK_BYTES << 15, '1);
        send_item(OP_RECORD, '0, CHUNK_W'(1));
        send_item(OP_RECORD, SIZE_W'(1), CHUNK_W'(2));
        send_item(OP_FREE, '0, CHUNK_W'(1));
        send_item(OP_FREE, '0, CHUNK_W'(2));
        send_item(OP_FREE, SIZE_MAX, '1);
        send_item(OP_ALLOC, '0, '0);
        send_item(OP_ALLOC, SIZE_W'(5), '0);
        send_item(OP_ALLOC, CHUNK_BYTES << 15, '0);
        send_item(OP_ALLOC, '0, '0);
    endtask

    // a chunk freed twice sits in its list twice with no complaint
    task automatic test_double_free();
        send_item(OP_RECORD, CHUNK_BYTES << 14, CHUNK_W'(3));
        send_item(OP_FREE, '0, CHUNK_W'(3));
        send_item(OP_FREE, '0, CHUNK_W'(3));
        send_item(OP_ALLOC, CHUNK_BYTES << 14, '0);
        send_item(OP_ALLOC, CHUNK_BYTES << 14, '0);
    endtask

    task automatic test_unused_operation();
        send_item(OP_NONE, SIZE_MAX, '1);
    endtask

    // host-like traffic: allocate, refill on a miss, free what was handed out
    task automatic test_random_traffic(input int item_total, input int gaps,
                                       input int stalls);
        int                 goal;
        int                 pick;
        int                 idx;
        logic [SIZE_W-1:0]  size;
        logic [CHUNK_W-1:0] chunk;
        gap_level   = gaps;
        stall_level = stalls;
        goal        = items_sent + item_total;
        while (items_sent < goal) begin
            pick = $urandom_range(99);
            if (pick < 40 || (pick < 75 && owned_chunks.size() == 0)) begin
                size = size_for_class(random_class());
                send_item(OP_ALLOC, size, CHUNK_W'($urandom));
                if (last_result.status == ST_OK) begin
                    claim_chunk(last_result.granted);
                end else if (last_result.status == ST_EMPTY && $urandom_range(3) != 0) begin
                    // miss: host maps fresh memory and tags it with the class
                    chunk = fresh_chunk();
                    send_item(OP_RECORD, size, chunk);
                    claim_chunk(chunk);
                end
            end else if (pick < 75) begin
                idx   = $urandom_range(owned_chunks.size() - 1);
                chunk = owned_chunks[idx];
                owned_chunks.delete(idx);
                is_owned[chunk] = 1'b0;
                send_item(OP_FREE, any_size(), chunk);
            end else if (pick < 85) begin
                chunk = fresh_chunk();
                send_item(OP_RECORD, size_for_class(random_class()), chunk);
                if (last_result.status == ST_OK)
                    claim_chunk(chunk);
            end else begin
                send_noise_item();
            end
        end
    endtask

    // sender holds off until every outstanding result is back, then resumes
    task automatic test_pause_until_drained();
        test_random_traffic(20, 0, 40);
        wait_results_drained();
        test_random_traffic(10, 0, 0);
    endtask

    initial begin
        gap_level   = 25;
        stall_level = 25;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        test_size_classes();
        test_chunk_checks();
        test_lifo_order();
        test_double_free();
        test_unused_operation();

        test_random_traffic(600, 30, 30);
        test_pause_until_drained();
        test_random_traffic(430, 60, 5);
        test_random_traffic(430, 5, 60);
        // final stretch at full rate, no idling either side
        test_random_traffic(380, 0, 0);

        wait_results_drained();
        repeat (20) @(posedge aclk);

        $display("Run covered %0d items: %0d allocate hits, %0d misses, %0d list pushes",
                 items_sent, alloc_hits, alloc_misses, frees_pushed);
        $display("%0d results compared, %0d errors", results_checked, error_count);
        if (error_count == 0 && expected_results.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
